>>> rtl/assert_macros.svh
// assertion macros used by matrix_multiply_core.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, held off during reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen at a rising edge
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/mm_pkg.sv
// types and constants for the matrix multiply core
`default_nettype none

package mm_pkg;

	localparam int MAX_DIM_DEF = 8;
	localparam int CFG_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int IDX_W       = 6;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 32;
	localparam int POS_W       = 3;

	typedef enum logic [1:0] {
		ACT_WRITE_A = 2'd0,
		ACT_WRITE_B = 2'd1,
		ACT_RUN     = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_M_ROWS  = 2'd0,
		REG_K_INNER = 2'd1,
		REG_N_COLS  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} mm_state_t;

	typedef struct packed {
		logic [1:0]               action;
		logic [IDX_W-1:0]         elem_index;
		logic signed [ELEM_W-1:0] elem_value;
	} mm_req_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] product_value;
		logic [POS_W-1:0]         out_row;
		logic [POS_W-1:0]         out_col;
		logic                     last;
	} mm_rsp_t;

endpackage

`default_nettype wire

>>> rtl/matrix_multiply_core.sv
// matrix multiply core: operand stores, one shared multiply-accumulate, result register
// load transfers are taken one per cycle while the core is idle and give no result
// a run holds the request side until its last result element is loaded: each result element
// takes K multiply-accumulate issues through the single MAC, a pipeline drain and an emit,
// plus any time the result side stalls
// reset clears the sequencer, pipeline valids and result valid; config registers reset to 8;
// the operand stores are not cleared
`default_nettype none

module matrix_multiply_core #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire mm_pkg::mm_req_t               req_item,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output mm_pkg::mm_rsp_t                    rsp_item,
	input  wire logic                          cfg_we,
	input  wire logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mm_pkg::CFG_W-1:0]      cfg_data
);

	import mm_pkg::*;
	`include "assert_macros.svh"

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int ACC_W = PROD_W + $clog2(MAX_DIM + 1);

	// configuration
	logic [CFG_W-1:0] m_rows_q, k_inner_q, n_cols_q;
	logic [DW-1:0]    m_eff, k_eff, n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_rows_q  <= CFG_W'(8);
			k_inner_q <= CFG_W'(8);
			n_cols_q  <= CFG_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_M_ROWS:  m_rows_q  <= cfg_data;
				REG_K_INNER: k_inner_q <= cfg_data;
				REG_N_COLS:  n_cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, above MAX_DIM acts as MAX_DIM
	function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] raw);
		if (raw == '0)
			return DW'(1);
		else if (raw > CFG_W'(MAX_DIM))
			return DW'(MAX_DIM);
		else
			return DW'(raw);
	endfunction

	assign m_eff = eff_dim(m_rows_q);
	assign k_eff = eff_dim(k_inner_q);
	assign n_eff = eff_dim(n_cols_q);

	// sequencer
	mm_state_t state_q, state_d;
	logic      req_accept, run_start, issue, emit_load, elem_last, row_end, t_end;
	logic      rd_v_s1, mul_v_s2;
	logic      first_s1, first_s2, last_s1, last_s2;

	logic [IW-1:0] i_q, j_q, t_q;
	logic [AW-1:0] a_addr_q, b_addr_q, a_row_q;

	assign req_accept = req_valid && !req_stall;
	assign run_start  = req_accept && (req_item.action == ACT_RUN);
	assign t_end      = (DW'(t_q) == k_eff - DW'(1));
	assign row_end    = (DW'(j_q) == n_eff - DW'(1));
	assign elem_last  = row_end && (DW'(i_q) == m_eff - DW'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (run_start) state_d = ST_MAC;
			ST_MAC:   if (t_end) state_d = ST_DRAIN;
			ST_DRAIN: if (mul_v_s2 && last_s2) state_d = ST_EMIT;
			ST_EMIT:  if (emit_load) state_d = elem_last ? ST_IDLE : ST_MAC;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		issue     = (state_q == ST_MAC);
		emit_load = (state_q == ST_EMIT) && (!rsp_valid || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// element counters and store addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
			a_row_q  <= '0;
		end else if (run_start) begin
			i_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			a_addr_q <= '0;
			b_addr_q <= '0;
			a_row_q  <= '0;
		end else if (issue) begin
			t_q      <= t_q + IW'(1);
			a_addr_q <= a_addr_q + AW'(1);
			b_addr_q <= b_addr_q + AW'(n_eff);
		end else if (emit_load) begin
			t_q <= '0;
			if (row_end) begin
				i_q      <= i_q + IW'(1);
				j_q      <= '0;
				a_row_q  <= a_row_q + AW'(k_eff);
				a_addr_q <= a_row_q + AW'(k_eff);
				b_addr_q <= '0;
			end else begin
				j_q      <= j_q + IW'(1);
				a_addr_q <= a_row_q;
				b_addr_q <= AW'(j_q) + AW'(1);
			end
		end
	end

	// operand stores
	logic signed [ELEM_W-1:0] mem_a [DEPTH];
	logic signed [ELEM_W-1:0] mem_b [DEPTH];
	logic signed [ELEM_W-1:0] a_rd_s1, b_rd_s1;
	logic                     wr_ok;
	logic [AW-1:0]            wr_addr;

	assign wr_ok   = req_accept && ((IDX_W + 1)'(req_item.elem_index) < (IDX_W + 1)'(DEPTH));
	assign wr_addr = req_item.elem_index[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_ok && req_item.action == ACT_WRITE_A)
			mem_a[wr_addr] <= req_item.elem_value;
		a_rd_s1 <= mem_a[a_addr_q];
	end

	always_ff @(posedge clk) begin
		if (wr_ok && req_item.action == ACT_WRITE_B)
			mem_b[wr_addr] <= req_item.elem_value;
		b_rd_s1 <= mem_b[b_addr_q];
	end

	// shared multiply-accumulate
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			mul_v_s2 <= 1'b0;
			first_s1 <= 1'b0;
			first_s2 <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
		end else begin
			rd_v_s1  <= issue;
			first_s1 <= issue && (t_q == '0);
			last_s1  <= issue && t_end;
			mul_v_s2 <= rd_v_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (mul_v_s2)
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
	end

	// saturate to signed Q16.16 when the upper accumulator bits are not a sign extension
	logic signed [PROD_W-1:0] sat_value;
	logic                     acc_fits;

	assign acc_fits  = (acc_q[ACC_W-1:PROD_W-1] == '0) || (acc_q[ACC_W-1:PROD_W-1] == '1);
	assign sat_value = acc_fits ? acc_q[PROD_W-1:0] :
		(acc_q[ACC_W-1] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}});

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid <= 1'b0;
		else if (emit_load)
			rsp_valid <= 1'b1;
		else if (!rsp_stall)
			rsp_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			rsp_item.product_value <= sat_value;
			rsp_item.out_row       <= POS_W'(i_q);
			rsp_item.out_col       <= POS_W'(j_q);
			rsp_item.last          <= elem_last;
		end
	end

	`ASSERT_CLK(a_mul_in_run, mul_v_s2 |-> (state_q == ST_MAC || state_q == ST_DRAIN),
		"product seen outside accumulation")
	`ASSERT_NEVER(a_emit_drained, (state_q == ST_EMIT) && (rd_v_s1 || mul_v_s2),
		"emit with products still in flight")
	`ASSERT_CLK(a_t_range, (state_q == ST_MAC) |-> (DW'(t_q) < k_eff),
		"inner index beyond dot product length")
	`ASSERT_CLK(a_last_idle, (emit_load && elem_last) |=> (state_q == ST_IDLE),
		"sequencer not idle after final element")

endmodule

`default_nettype wire
